// ===== rtl/gim_pkg.sv =====
package gim_pkg;

  localparam logic [63:0] Prime = 64'hFFFF_FFFF_0000_0001;
  // 2^64 mod p, used to fold a carry or borrow out of a 64-bit word back in.
  localparam logic [63:0] Eps   = 64'h0000_0000_FFFF_FFFF;

  // Stages inside the field multiplier, and from acceptance to a valid result.
  localparam int unsigned MulLat = 4;
  localparam int unsigned Lat    = 9;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  function automatic logic [63:0] fold_in(input logic [63:0] v);
    return (v >= Prime) ? (v - Prime) : v;
  endfunction

  function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = s[63:0];
    if (s[64]) r = r + Eps;
    if (r >= Prime) r = r - Prime;
    return r;
  endfunction

  function automatic logic [63:0] fsub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a < b) r = r - Eps;
    return r;
  endfunction

endpackage

// ===== rtl/gaussian_int_mod_prime_alu.sv =====
// A transaction passes the input, operand-reduction, operand-sum, multiplier, subtraction and
// result registers, in that order, before its result is offered.
// Throughput: one transaction per cycle, sustained; a stalled output holds the whole pipe.
// The depth is set by the four-stage field multiplier built from 32x32 partial products.
// Reset (rst_ni low, asynchronous) clears all valid flags; the datapath is not reset.
module gaussian_int_mod_prime_alu
  import gim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] x_re_i,
  input  logic [63:0] x_im_i,
  input  logic [63:0] y_re_i,
  input  logic [63:0] y_im_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] z_re_o,
  output logic [63:0] z_im_o
);

  // The pipe moves as one: every stage advances whenever the output register is free or
  // being emptied. Bubbles travel with their own valid flag.
  logic adv;
  logic [Lat-1:0] vld_d, vld_q;

  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[Lat-1];

  always_comb begin
    vld_d = vld_q;
    if (adv) vld_d = {vld_q[Lat-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1 holds the raw transaction; stage 2 the operands brought into [0, p-1].
  logic [1:0]  op1_q;
  logic [63:0] xr1_q, xi1_q, yr1_q, yi1_q;
  op_e         op2_q;
  logic [63:0] xr2_q, xi2_q, yr2_q, yi2_q;

  // Stage 3: the sum or difference is finished here, and the Karatsuba operand sums are
  // formed for the multipliers.
  op_e         op3_q;
  logic [63:0] xr3_q, xi3_q, yr3_q, yi3_q, sx3_q, sy3_q;
  logic [63:0] ar3_d, ai3_d, ar3_q, ai3_q;

  always_comb begin
    unique case (op2_q)
      OP_ADD: begin
        ar3_d = fadd(xr2_q, yr2_q);
        ai3_d = fadd(xi2_q, yi2_q);
      end
      OP_SUB: begin
        ar3_d = fsub(xr2_q, yr2_q);
        ai3_d = fsub(xi2_q, yi2_q);
      end
      default: begin
        ar3_d = '0;
        ai3_d = '0;
      end
    endcase
  end

  // Three field multiplications: xr*yr, xi*yi and (xr+xi)*(yr+yi).
  logic [63:0] s1, s2, s3;

  gim_fmul u_mul_re (.clk_i, .en_i(adv), .a_i(xr3_q), .b_i(yr3_q), .p_o(s1));
  gim_fmul u_mul_im (.clk_i, .en_i(adv), .a_i(xi3_q), .b_i(yi3_q), .p_o(s2));
  gim_fmul u_mul_kr (.clk_i, .en_i(adv), .a_i(sx3_q), .b_i(sy3_q), .p_o(s3));

  // The operation and the add/sub result ride alongside the multipliers.
  op_e         op_dl_q [MulLat];
  logic [63:0] ar_dl_q [MulLat];
  logic [63:0] ai_dl_q [MulLat];

  // Stage 8: the first Karatsuba subtractions.
  op_e         op8_q;
  logic [63:0] zr8_q, d8_q, s2_8_q, ar8_q, ai8_q;

  // Stage 9, the result register.
  logic [63:0] zr_d, zi_d, zr_q, zi_q;

  always_comb begin
    if (op8_q == OP_MUL) begin
      zr_d = zr8_q;
      zi_d = fsub(d8_q, s2_8_q);
    end else begin
      zr_d = ar8_q;
      zi_d = ai8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= operation_i;
      xr1_q <= x_re_i;
      xi1_q <= x_im_i;
      yr1_q <= y_re_i;
      yi1_q <= y_im_i;

      op2_q <= op_e'(op1_q);
      xr2_q <= fold_in(xr1_q);
      xi2_q <= fold_in(xi1_q);
      yr2_q <= fold_in(yr1_q);
      yi2_q <= fold_in(yi1_q);

      op3_q <= op2_q;
      xr3_q <= xr2_q;
      xi3_q <= xi2_q;
      yr3_q <= yr2_q;
      yi3_q <= yi2_q;
      sx3_q <= fadd(xr2_q, xi2_q);
      sy3_q <= fadd(yr2_q, yi2_q);
      ar3_q <= ar3_d;
      ai3_q <= ai3_d;

      op_dl_q[0] <= op3_q;
      ar_dl_q[0] <= ar3_q;
      ai_dl_q[0] <= ai3_q;
      for (int i = 1; i < MulLat; i++) begin
        op_dl_q[i] <= op_dl_q[i-1];
        ar_dl_q[i] <= ar_dl_q[i-1];
        ai_dl_q[i] <= ai_dl_q[i-1];
      end

      op8_q  <= op_dl_q[MulLat-1];
      ar8_q  <= ar_dl_q[MulLat-1];
      ai8_q  <= ai_dl_q[MulLat-1];
      zr8_q  <= fsub(s1, s2);
      d8_q   <= fsub(s3, s1);
      s2_8_q <= s2;

      zr_q <= zr_d;
      zi_q <= zi_d;
    end
  end

  assign z_re_o = zr_q;
  assign z_im_o = zi_q;

endmodule

// ===== rtl/gim_fmul.sv =====
module gim_fmul
  import gim_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  // Four 32x32 partial products.
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_d, prod_q;
  logic [63:0]  t_d, t_q, m_d, m_q;
  logic [63:0]  s_q;
  logic [31:0]  h0, h1;

  always_comb begin
    prod_d = {p11_q, p00_q} + {32'b0, p01_q, 32'b0} + {32'b0, p10_q, 32'b0};
  end

  // Using 2^64 = 2^32 - 1 and 2^96 = -1 modulo p.
  assign h0 = prod_q[95:64];
  assign h1 = prod_q[127:96];

  always_comb begin
    t_d = prod_q[63:0] - {32'b0, h1};
    if (prod_q[63:0] < {32'b0, h1}) t_d = t_d - Eps;
    m_d = {h0, 32'b0} - {32'b0, h0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= {32'b0, a_i[31:0]}  * {32'b0, b_i[31:0]};
      p01_q  <= {32'b0, a_i[31:0]}  * {32'b0, b_i[63:32]};
      p10_q  <= {32'b0, a_i[63:32]} * {32'b0, b_i[31:0]};
      p11_q  <= {32'b0, a_i[63:32]} * {32'b0, b_i[63:32]};
      prod_q <= prod_d;
      t_q    <= t_d;
      m_q    <= m_d;
      s_q    <= fadd(t_q, m_q);
    end
  end

  assign p_o = s_q;

endmodule

// ===== rtl/gim_checker.sv =====
module gim_checker
  import gim_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] z_re_o,
  input logic [63:0] z_im_o
);

  // The input side may only stall while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (z_re_o < Prime))
    else $error("real part of result not fully reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (z_im_o < Prime))
    else $error("imaginary part of result not fully reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(z_re_o) && $stable(z_im_o)))
    else $error("stalled result transaction changed");

endmodule

bind gaussian_int_mod_prime_alu gim_checker u_gim_checker (.*);
